>>> hdl/tcce_pkg.sv
// tcce_pkg: shared types, screen geometry and helpers for the text console engine
// used by tcce_ram users and text_console_char_engine_core; no dependencies
package tcce_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    // derived widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int ROW_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int CELL_W = 16;

    // opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // reset cell: space in light grey on black
    localparam logic [CELL_W-1:0] BLANK_GREY = 16'h0720;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } req_beat_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
        logic        scrolled;
    } rsp_beat_t;

    // attribute in the high byte, character in the low byte
    function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                    input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

>>> hdl/text_console_char_engine_core.sv
// a read, a newline, a printed byte and a backspace inside a row pass from idle through fin to the output register;
// a backspace at a row start scans back over the previous row, reading and then testing one column at a time;
// a scroll copies the screen rows up through the ram, one cell a cycle, then blanks the last row.
// one item at a time: the next beat is taken once the sequencer is back in idle.
// reset: a clearing pass writes blank grey to all CELL_COUNT cells, no beat taken
// text_console_char_engine_core: top level, uses tcce_pkg and tcce_ram
module text_console_char_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tcce_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tcce_pkg::rsp_beat_t rsp
);
    import tcce_pkg::*;

    // sequencer states
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,  // post-reset blanking pass
        ST_IDLE   = 7'b0000010,  // waiting for a request beat
        ST_FIN    = 7'b0000100,  // result ready, waiting for the output slot
        ST_COPY   = 7'b0001000,  // scroll: move rows up one cell a cycle
        ST_BLANK  = 7'b0010000,  // scroll: blank the last row
        ST_BS_RD  = 7'b0100000,  // backspace scan: read one cell
        ST_BS_CHK = 7'b1000000   // backspace scan: test the cell read
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         color_reg, color_next;
    logic               is_read_reg, is_read_next;
    logic               in_range_reg, in_range_next;
    logic               scrolled_reg, scrolled_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_beat_t          rsp_reg, rsp_next;

    // ram port signals
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    // cursor helpers
    logic [ADDR_W-1:0]  lin;
    logic               row_at_end;
    logic               col_at_end;
    logic               req_fire;

    assign lin        = ADDR_W'(32'(row_reg) * SCREEN_WIDTH + 32'(col_reg));
    assign row_at_end = (32'(row_reg) + 32'd1) >= SCREEN_HEIGHT;
    assign col_at_end = (32'(col_reg) + 32'd1) >= SCREEN_WIDTH;
    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic go_next_row;

        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        color_next     = color_reg;
        is_read_next   = is_read_reg;
        in_range_next  = in_range_reg;
        scrolled_next  = scrolled_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        go_next_row    = 1'b0;

        // output slot drains independently of the sequencer
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cnt_reg);
                ram_wdata = BLANK_GREY;
                if (32'(cnt_reg) == CELL_COUNT - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_fire)
                begin
                    color_next    = req.color;
                    scrolled_next = 1'b0;
                    is_read_next  = (req.opcode == OP_READ);
                    in_range_next = 32'(req.cell_index) < CELL_COUNT;
                    state_next    = ST_FIN;
                    if (req.opcode == OP_READ)
                    begin
                        // out-of-range reads return zero without touching the ram
                        if (32'(req.cell_index) < CELL_COUNT)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_W'(req.cell_index);
                        end
                    end
                    else
                    begin
                        case (req.char_code)
                            CH_NEWLINE:
                            begin
                                go_next_row = 1'b1;
                            end
                            CH_BACKSPACE:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next  = col_reg - COL_W'(1);
                                    ram_we    = 1'b1;
                                    ram_waddr = lin - ADDR_W'(1);
                                    ram_wdata = make_cell(CH_SPACE, req.color);
                                end
                                else if (row_reg != '0)
                                begin
                                    // row start: scan back from the previous row's last column
                                    row_next   = row_reg - ROW_W'(1);
                                    col_next   = COL_W'(SCREEN_WIDTH - 1);
                                    state_next = ST_BS_RD;
                                end
                            end
                            default:
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = lin;
                                ram_wdata = make_cell(req.char_code, req.color);
                                if (col_at_end)
                                begin
                                    go_next_row = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                        endcase

                        if (go_next_row)
                        begin
                            col_next = '0;
                            if (row_at_end)
                            begin
                                scrolled_next = 1'b1;
                                row_next      = ROW_W'(SCREEN_HEIGHT - 1);
                                cnt_next      = CNT_W'(SCREEN_WIDTH);
                                pend_next     = 1'b0;
                                state_next    = ST_COPY;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                    end
                end
            end

            ST_COPY:
            begin
                // read runs one row and one cell ahead of the write, so no entry is hit twice in a cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (32'(cnt_reg) < CELL_COUNT)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = ADDR_W'(cnt_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(32'(cnt_reg) - SCREEN_WIDTH);
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = CNT_W'(CELL_COUNT - SCREEN_WIDTH);
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cnt_reg);
                ram_wdata = make_cell(CH_SPACE, color_reg);
                if (32'(cnt_reg) == CELL_COUNT - 1)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_BS_RD:
            begin
                if (col_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = lin;
                    ram_wdata  = make_cell(CH_SPACE, color_reg);
                    state_next = ST_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lin;
                    state_next = ST_BS_CHK;
                end
            end

            ST_BS_CHK:
            begin
                if (ram_rdata[7:0] != CH_SPACE)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = lin;
                    ram_wdata  = make_cell(CH_SPACE, color_reg);
                    state_next = ST_FIN;
                end
                else
                begin
                    col_next   = col_reg - COL_W'(1);
                    state_next = ST_BS_RD;
                end
            end

            ST_FIN:
            begin
                // read data stays in the ram output register, no other read since the beat
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.cursor_row      = 5'(row_reg);
                    rsp_next.cursor_col      = 7'(col_reg);
                    rsp_next.cursor_position = 11'(lin);
                    rsp_next.cell_data       = (is_read_reg && in_range_reg) ?
                                               16'(ram_rdata) : 16'h0000;
                    rsp_next.scrolled        = scrolled_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        is_read_reg   <= is_read_next;
        in_range_reg  <= in_range_next;
        scrolled_reg  <= scrolled_next;
        pend_addr_reg <= pend_addr_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // cursor never leaves the screen
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < SCREEN_WIDTH) && (32'(row_reg) < SCREEN_HEIGHT))
        else $error("cursor outside the screen");

    // scroll copy writes strictly below the cell being read
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && ram_we && ram_re) |-> (ram_waddr < ram_raddr))
        else $error("scroll copy write overtakes its read");

    // a scrolled beat leaves the cursor at the start of a line
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.scrolled) |-> (rsp.cursor_col == 7'd0))
        else $error("scrolled beat with cursor off column zero");

    // a new result is loaded only into a free or draining output slot
    a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && rsp_valid_reg && !rsp_ready) |=> (state_reg == ST_FIN))
        else $error("result left fin while output slot was full");

endmodule

>>> hdl/tcce_ram.sv
// tcce_ram: generic simple dual-port ram, one write and one registered read port
// no package dependencies
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
